@@ rtl/cml_pkg.sv @@
// shared constants, codes and types of the cluster majority labeler
// no dependencies
package cml_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_CLASSES  = 16;
    localparam int COUNT_BITS   = 16;

    localparam int DEPTH  = MAX_CLUSTERS * MAX_CLASSES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int LBL_W  = $clog2(MAX_CLASSES + 1);
    localparam int MAXM   = (MAX_CLASSES > MAX_CLUSTERS) ? MAX_CLASSES : MAX_CLUSTERS;
    localparam int USE_W  = ($clog2(MAXM + 1) > 5) ? $clog2(MAXM + 1) : 5;

    localparam int ACTION_W   = 2;
    localparam int CLUSTER_W  = 4;
    localparam int TCLASS_W   = 5;
    localparam int SCLASS_W   = 6;
    localparam int LABEL_W    = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = 16;

    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ACC   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EVAL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLASSES  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } st_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [CLUSTER_W-1:0] cluster;
        logic [TCLASS_W-1:0]  true_class;
    } item_t;

    typedef struct packed {
        logic [USE_W-1:0] n_clu;
        logic [USE_W-1:0] n_cls;
    } cfg_t;

    typedef struct packed {
        logic                  rd_en;
        logic                  wr_en;
        logic                  clr;
        logic [ADDR_W-1:0]     addr;
        logic [COUNT_BITS-1:0] wdata;
    } tbl_req_t;

    typedef struct packed {
        logic signed [SCLASS_W-1:0] signed_class;
        logic [LABEL_W-1:0]         cluster_label;
        logic                       matched;
    } res_t;

endpackage

@@ rtl/cml_table.sv @@
// count table: synchronous single-port memory with a registered read
// and per-entry valid bits so a clear needs no pass over the entries; uses cml_pkg
module cml_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cml_pkg::tbl_req_t               req,
    output logic [cml_pkg::COUNT_BITS-1:0]  rd_data
);
    import cml_pkg::*;

    logic [COUNT_BITS-1:0] mem_ram [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    logic [COUNT_BITS-1:0] q_reg;
    logic                  qv_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_ram[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            q_reg <= mem_ram[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || req.clr) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg <= 1'b0;
        end else if (req.rd_en) begin
            qv_reg <= valid_reg[req.addr];
        end
    end

    assign rd_data = qv_reg ? q_reg : '0;

    a_no_wr_on_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.clr && (req.wr_en || req.rd_en)))
        else $error("table cleared while accessed");

    a_clr_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        req.clr |=> (valid_reg == '0))
        else $error("valid bits not cleared");

    a_wr_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en && !req.clr |=> valid_reg[$past(req.addr)])
        else $error("written entry not marked valid");

endmodule

@@ rtl/cml_seq.sv @@
// request sequencer: read-modify-write for accumulate, row scan for evaluate
// uses cml_pkg and drives the cml_table request port
module cml_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cml_pkg::item_t                  item,
    input  cml_pkg::cfg_t                   cfg,
    output cml_pkg::tbl_req_t               tbl_req,
    input  logic [cml_pkg::COUNT_BITS-1:0]  rd_data,
    output logic                            res_valid,
    input  logic                            res_ready,
    output cml_pkg::res_t                   res
);
    import cml_pkg::*;

    st_t                   state_reg, state_next;
    logic [CLUSTER_W-1:0]  cl_reg, cl_next;
    logic [TCLASS_W-1:0]   tc_reg, tc_next;
    logic [CLS_W-1:0]      idx_reg, idx_next;
    logic [CLS_W-1:0]      pidx_reg;
    logic                  pend_reg;
    logic [COUNT_BITS-1:0] best_reg, best_next;
    logic [LBL_W-1:0]      label_reg, label_next;

    logic accept;
    logic acc_ok;
    logic eval_ok;
    logic scan_last;
    logic match;
    logic [ADDR_W-1:0] row_base;
    logic [CLS_W-1:0]  acc_col;

    assign accept    = in_valid && in_ready;
    assign acc_ok    = (USE_W'(item.cluster) < cfg.n_clu) && (item.true_class != '0)
                       && (USE_W'(item.true_class) <= cfg.n_cls);
    assign eval_ok   = (USE_W'(item.cluster) < cfg.n_clu) && (cfg.n_cls != '0);
    assign scan_last = (USE_W'(idx_reg) + USE_W'(1)) == cfg.n_cls;
    assign row_base  = ADDR_W'(cl_reg) * ADDR_W'(MAX_CLASSES);
    assign acc_col   = CLS_W'(tc_reg - TCLASS_W'(1));
    assign match     = (label_reg != '0) && (USE_W'(label_reg) == USE_W'(tc_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (item.action)
                        ACT_ACC:  state_next = acc_ok ? ST_ACC_RD : ST_IDLE;
                        ACT_EVAL: state_next = eval_ok ? ST_SCAN : ST_RESULT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC_RD: state_next = ST_ACC_WR;
            ST_ACC_WR: state_next = ST_IDLE;
            ST_SCAN:   state_next = scan_last ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:  state_next = ST_RESULT;
            ST_RESULT: state_next = res_ready ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        tbl_req       = '0;
        tbl_req.addr  = row_base + ADDR_W'(acc_col);
        tbl_req.wdata = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
        case (state_reg)
            ST_IDLE: begin
                in_ready    = aresetn;
                tbl_req.clr = in_valid && (item.action == ACT_CLEAR);
            end
            ST_ACC_RD: tbl_req.rd_en = 1'b1;
            ST_ACC_WR: tbl_req.wr_en = 1'b1;
            ST_SCAN: begin
                tbl_req.rd_en = 1'b1;
                tbl_req.addr  = row_base + ADDR_W'(idx_reg);
            end
            ST_RESULT: res_valid = res_ready;
            default: ;
        endcase
        res.cluster_label = LABEL_W'(label_reg);
        res.matched       = match;
        res.signed_class  = match ? SCLASS_W'(tc_reg) : -SCLASS_W'(tc_reg);
    end

    // datapath
    always_comb begin
        cl_next    = cl_reg;
        tc_next    = tc_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        label_next = label_reg;
        if (accept) begin
            cl_next    = item.cluster;
            tc_next    = item.true_class;
            idx_next   = '0;
            best_next  = '0;
            label_next = '0;
        end else begin
            if (state_reg == ST_SCAN) begin
                idx_next = idx_reg + CLS_W'(1);
            end
            if (pend_reg && (rd_data > best_reg)) begin
                best_next  = rd_data;
                label_next = LBL_W'(pidx_reg) + LBL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCAN);
        end
    end

    always_ff @(posedge aclk) begin
        cl_reg    <= cl_next;
        tc_reg    <= tc_next;
        idx_reg   <= idx_next;
        pidx_reg  <= idx_reg;
        best_reg  <= best_next;
        label_reg <= label_next;
    end

    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ACC_RD |=> state_reg == ST_ACC_WR)
        else $error("accumulate write does not follow its read");

    a_match_label: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.matched |-> res.cluster_label != '0)
        else $error("match reported without a label");

    a_pend_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg) == ST_SCAN)
        else $error("scan compare without a scan read");

endmodule

@@ rtl/cluster_majority_labeler_top.sv @@
// top level of the cluster majority labeler: stream ports, configuration
// registers and result register; uses cml_pkg, cml_seq and cml_table
//
// Keeps a cluster-by-class count table in a single-port memory with a
// registered read, cleared at reset or by a clear request through per-entry
// valid bits (no clearing pass). One request is worked on at a time: a clear
// or an ignored request ends at its accept, an accumulate goes through accept,
// read and saturating write-back, and an evaluate through accept, one memory
// read per class of the row, a last compare and the hand-off to the result
// register, or accept and hand-off alone when the cluster is out of use or
// no class is in use. The memory port, read once per class, sets the evaluate
// time. A result left in the output register stalls only evaluate hand-offs.
module cluster_majority_labeler_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // action[1:0], cluster[5:2], true_class[10:6], zero above
    input  logic [cml_pkg::TDATA_W-1:0]       s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // signed_class[5:0], cluster_label[10:6], matched[11], zero above
    output logic [cml_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cml_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cml_pkg::CFG_W-1:0]         cfg_data
);
    import cml_pkg::*;

    logic [CFG_W-1:0]   num_clusters_reg;
    logic [CFG_W-1:0]   num_classes_reg;
    logic               m_valid_reg;
    res_t               m_data_reg;

    item_t                 item;
    cfg_t                  cfg;
    tbl_req_t              tbl_req;
    logic [COUNT_BITS-1:0] rd_data;
    logic                  res_valid;
    logic                  res_ready;
    res_t                  res;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= CFG_W'(16);
            num_classes_reg  <= CFG_W'(16);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_NUM_CLUSTERS: num_clusters_reg <= cfg_data;
                REG_NUM_CLASSES:  num_classes_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // used counts, capped at the table size
    assign cfg.n_clu = (USE_W'(num_clusters_reg) > USE_W'(MAX_CLUSTERS))
                       ? USE_W'(MAX_CLUSTERS) : USE_W'(num_clusters_reg);
    assign cfg.n_cls = (USE_W'(num_classes_reg) > USE_W'(MAX_CLASSES))
                       ? USE_W'(MAX_CLASSES) : USE_W'(num_classes_reg);

    assign item.action     = s_tdata[ACTION_W-1:0];
    assign item.cluster    = s_tdata[ACTION_W +: CLUSTER_W];
    assign item.true_class = s_tdata[ACTION_W + CLUSTER_W +: TCLASS_W];

    cml_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .cfg       (cfg),
        .tbl_req   (tbl_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    cml_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tbl_req),
        .rd_data (rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(TDATA_W - SCLASS_W - LABEL_W - 1)'(0), m_data_reg.matched,
                       m_data_reg.cluster_label, m_data_reg.signed_class};

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a waiting result");

endmodule

@@ tb/cluster_majority_labeler_top_test.sv @@
// self-checking testbench for cluster_majority_labeler_top: directed table and
// random phases over several register settings, checked against a count-table predictor
// depends on cml_pkg and the rtl of cluster_majority_labeler_top
`timescale 1ns / 1ps

module cluster_majority_labeler_top_test;
    import cml_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
    localparam int PLAN_ROWS   = 21;
    localparam int SETTLE      = MAX_CLASSES + 4;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [CLUSTER_W-1:0] cluster;
        logic [TCLASS_W-1:0]  true_class;
        logic                 fixed;
        logic [SCLASS_W-1:0]  signed_class;
        logic [LABEL_W-1:0]   cluster_label;
        logic                 matched;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [TDATA_W-1:0]    s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    logic [COUNT_BITS-1:0] tally [MAX_CLUSTERS][MAX_CLASSES];
    logic [CFG_W-1:0]      cfg_clusters = 5'd16;
    logic [CFG_W-1:0]      cfg_classes = 5'd16;
    res_t                  expected_results [$];
    plan_row_t             plan [PLAN_ROWS];
    int                    errors = 0;
    int                    s_idle_pct = 0;
    int                    r_stall_pct = 0;
    int                    hold_asked = 0;
    int                    hold_taken = 0;
    int                    hold_left = 0;
    int                    quiet = 0;

    cluster_majority_labeler_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned clusters_in_use();
        return (cfg_clusters > MAX_CLUSTERS) ? MAX_CLUSTERS : cfg_clusters;
    endfunction

    function automatic int unsigned classes_in_use();
        return (cfg_classes > MAX_CLASSES) ? MAX_CLASSES : cfg_classes;
    endfunction

    // updates the count table and returns 1 when the request yields a label result
    function automatic bit label_step(input item_t it, output res_t r);
        int unsigned nclu;
        int unsigned ncls;
        int unsigned best;
        int unsigned lbl;
        int unsigned cl;
        int unsigned tc;
        bit hit;
        bit produced;
        nclu = clusters_in_use();
        ncls = classes_in_use();
        cl = it.cluster;
        tc = it.true_class;
        r = '0;
        produced = 1'b0;
        case (it.action)
            ACT_CLEAR: begin
                for (int i = 0; i < MAX_CLUSTERS; i++)
                    for (int j = 0; j < MAX_CLASSES; j++)
                        tally[i][j] = '0;
            end
            ACT_ACC: begin
                if (cl < nclu && tc >= 1 && tc <= ncls && tally[cl][tc-1] != '1)
                    tally[cl][tc-1] = tally[cl][tc-1] + 1'b1;
            end
            ACT_EVAL: begin
                best = 0;
                lbl = 0;
                if (cl < nclu) begin
                    for (int j = 0; j < ncls; j++) begin
                        if (tally[cl][j] > best) begin
                            best = tally[cl][j];
                            lbl = j + 1;
                        end
                    end
                end
                hit = (lbl != 0 && lbl == tc);
                r.signed_class = hit ? SCLASS_W'(tc) : SCLASS_W'(-int'(tc));
                r.cluster_label = LABEL_W'(lbl);
                r.matched = hit;
                produced = 1'b1;
            end
            default: ;
        endcase
        return produced;
    endfunction

    function automatic item_t draw_item();
        int unsigned roll;
        int unsigned nclu;
        int unsigned ncls;
        item_t it;
        nclu = clusters_in_use();
        ncls = classes_in_use();
        roll = $urandom_range(99);
        if (roll < 2)
            it.action = ACT_CLEAR;
        else if (roll < 4)
            it.action = ACT_NONE;
        else if (roll < 30)
            it.action = ACT_EVAL;
        else
            it.action = ACT_ACC;
        if (nclu > 0 && $urandom_range(99) < 88)
            it.cluster = CLUSTER_W'($urandom_range(nclu - 1));
        else
            it.cluster = CLUSTER_W'($urandom_range(MAX_CLUSTERS - 1));
        roll = $urandom_range(99);
        // a favorite class per cluster gives rows a clear majority
        if (ncls == 0 || roll < 10)
            it.true_class = TCLASS_W'($urandom_range(31));
        else if (roll < 55)
            it.true_class = TCLASS_W'((it.cluster % ncls) + 1);
        else
            it.true_class = TCLASS_W'($urandom_range(ncls, 1));
        return it;
    endfunction

    task automatic offer(input item_t it, input bit fixed, input res_t typed);
        res_t predicted;
        while ($urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, it.true_class, it.cluster, it.action};
        do @(posedge aclk); while (!s_tready);
        if (label_step(it, predicted))
            expected_results.push_back(fixed ? typed : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_NUM_CLUSTERS)
            cfg_clusters = val;
        else
            cfg_classes = val;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] clu, input logic [CFG_W-1:0] cls);
        write_reg(REG_NUM_CLUSTERS, clu);
        write_reg(REG_NUM_CLASSES, cls);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] clu, input logic [CFG_W-1:0] cls,
                             input int s_idle, input int r_stall, input int n,
                             input bit long_hold);
        wait_drained();
        set_config(clu, cls);
        s_idle_pct = s_idle;
        r_stall_pct <= r_stall;
        if (long_hold)
            hold_asked <= hold_asked + 1;
        repeat (n) offer(draw_item(), 1'b0, '0);
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left <= HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= r_stall_pct);
        end
    end

    always @(posedge aclk) begin : label_check
        res_t want;
        logic signed [SCLASS_W-1:0] got_sc;
        logic [LABEL_W-1:0] got_lbl;
        logic got_mt;
        if (aresetn && m_tvalid && m_tready) begin
            got_sc = m_tdata[5:0];
            got_lbl = m_tdata[10:6];
            got_mt = m_tdata[11];
            if (expected_results.size() == 0) begin
                $error("unexpected result: tdata %h", m_tdata);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got_sc !== want.signed_class) begin
                    $error("signed_class: expected %0d, got %0d", want.signed_class, got_sc);
                    errors++;
                end
                if (got_lbl !== want.cluster_label) begin
                    $error("cluster_label: expected %0d, got %0d", want.cluster_label, got_lbl);
                    errors++;
                end
                if (got_mt !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, got_mt);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("FAIL cluster_majority_labeler_top");
            $finish;
        end
    end

    initial begin
        item_t it;
        res_t typed;
        for (int i = 0; i < MAX_CLUSTERS; i++)
            for (int j = 0; j < MAX_CLASSES; j++)
                tally[i][j] = '0;
        plan = '{
            '{ACT_EVAL,  4'd0,  5'd1,  1'b1, 6'h3f, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd15, 5'd16, 1'b1, 6'h30, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd3,  5'd0,  1'b1, 6'h00, 5'd0,  1'b0},
            '{ACT_ACC,   4'd0,  5'd1,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd0,  5'd1,  1'b1, 6'h01, 5'd1,  1'b1},
            '{ACT_EVAL,  4'd0,  5'd2,  1'b1, 6'h3e, 5'd1,  1'b0},
            '{ACT_ACC,   4'd15, 5'd16, 1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_ACC,   4'd15, 5'd16, 1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_ACC,   4'd15, 5'd3,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd15, 5'd16, 1'b1, 6'h10, 5'd16, 1'b1},
            '{ACT_ACC,   4'd15, 5'd3,  1'b0, 6'h00, 5'd0,  1'b0},
            // tie: the lower class wins
            '{ACT_EVAL,  4'd15, 5'd3,  1'b1, 6'h03, 5'd3,  1'b1},
            '{ACT_ACC,   4'd7,  5'd0,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_ACC,   4'd7,  5'd31, 1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd7,  5'd31, 1'b1, 6'h21, 5'd0,  1'b0},
            '{ACT_NONE,  4'd9,  5'd5,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_ACC,   4'd9,  5'd5,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd9,  5'd17, 1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_CLEAR, 4'd0,  5'd0,  1'b0, 6'h00, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd15, 5'd3,  1'b1, 6'h3d, 5'd0,  1'b0},
            '{ACT_EVAL,  4'd0,  5'd1,  1'b1, 6'h3f, 5'd0,  1'b0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int k = 0; k < PLAN_ROWS; k++) begin
            it.action = plan[k].action;
            it.cluster = plan[k].cluster;
            it.true_class = plan[k].true_class;
            typed.signed_class = plan[k].signed_class;
            typed.cluster_label = plan[k].cluster_label;
            typed.matched = plan[k].matched;
            offer(it, plan[k].fixed, typed);
        end

        run_phase(5'd16, 5'd16, 0,  0,  100, 1'b0);
        run_phase(5'd1,  5'd1,  56, 0,  100, 1'b0);
        run_phase(5'd31, 5'd31, 0,  56, 100, 1'b0);
        run_phase(5'd0,  5'd0,  14, 14, 60,  1'b0);
        run_phase(5'd5,  5'd3,  0,  0,  100, 1'b1);
        run_phase(5'd16, 5'd16, 14, 14, 60,  1'b0);
        run_phase(5'($urandom_range(31)), 5'($urandom_range(31)), 14, 14, 80, 1'b0);

        wait_drained();
        if (errors == 0)
            $display("PASS cluster_majority_labeler_top");
        else
            $display("FAIL cluster_majority_labeler_top");
        $finish;
    end

endmodule
